// ----- hdl/srbf_pkg.sv -----
// ----------------------------------------------------------------------------
// srbf_pkg
// Types, register indexes and helper functions for the sumo behaviour FSM.
// ----------------------------------------------------------------------------
package srbf_pkg;

    // Operating modes, as reported on the mode port
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_CAL    = 3'd1,
        MODE_COUNT  = 3'd2,
        MODE_SEARCH = 3'd3,
        MODE_ATTACK = 3'd4,
        MODE_EVADE  = 3'd5,
        MODE_STOP   = 3'd6
    } mode_t;

    // Opponent bearing codes
    typedef enum logic [2:0] {
        OPP_NONE        = 3'd0,
        OPP_FRONT       = 3'd1,
        OPP_FRONT_LEFT  = 3'd2,
        OPP_FRONT_RIGHT = 3'd3,
        OPP_LEFT        = 3'd4,
        OPP_RIGHT       = 3'd5,
        OPP_REAR        = 3'd6,
        OPP_UNUSED      = 3'd7
    } opp_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ATTACK_SPEED   = 3'd0,
        CFG_TURN_SPEED     = 3'd1,
        CFG_SEARCH_SPEED   = 3'd2,
        CFG_START_DELAY    = 3'd3,
        CFG_SWEEP_SEGMENT  = 3'd4,
        CFG_ATTACK_WDOG    = 3'd5,
        CFG_EVADE_REVERSE  = 3'd6,
        CFG_EVADE_TURN     = 3'd7
    } cfg_idx_t;

    localparam int unsigned SPEED_W = 8;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned MOTOR_W = 9;
    localparam int unsigned CFG_W   = 16;

    localparam logic [31:0] CAL_TIME_MS = 32'd4000;

    // Reset values of the configuration registers
    localparam logic [SPEED_W-1:0] RST_ATTACK_SPEED = 8'd255;
    localparam logic [SPEED_W-1:0] RST_TURN_SPEED   = 8'd180;
    localparam logic [SPEED_W-1:0] RST_SEARCH_SPEED = 8'd120;
    localparam logic [TIME_W-1:0]  RST_START_DELAY  = 16'd5000;
    localparam logic [TIME_W-1:0]  RST_SWEEP_SEG    = 16'd600;
    localparam logic [TIME_W-1:0]  RST_ATTACK_WDOG  = 16'd10000;
    localparam logic [TIME_W-1:0]  RST_EVADE_REV    = 16'd300;
    localparam logic [TIME_W-1:0]  RST_EVADE_TURN   = 16'd400;

    // Veer speed: floor(s * 3 / 5), done as (s * 615) >> 10, exact for s < 343
    localparam logic [9:0] VEER_MULT = 10'd615;

    function automatic logic [SPEED_W-1:0] veer_slow(input logic [SPEED_W-1:0] s);
        logic [17:0] prod;
        prod = {10'd0, s} * {8'd0, VEER_MULT};
        return prod[17:10];
    endfunction

    // Speed to signed wheel command, forward and reverse
    function automatic logic signed [MOTOR_W-1:0] fwd(input logic [SPEED_W-1:0] s);
        return $signed({1'b0, s});
    endfunction

    function automatic logic signed [MOTOR_W-1:0] rev(input logic [SPEED_W-1:0] s);
        return -$signed({1'b0, s});
    endfunction

endpackage

// ----- hdl/sumo_robot_behaviour_fsm.sv -----
// ----------------------------------------------------------------------------
// sumo_robot_behaviour_fsm
// Mode sequencer and held motor command for a sumo robot control loop.
// ----------------------------------------------------------------------------
// An accepted update's result reaches the output port in the next cycle.
// Throughput: 1 update per cycle unless out_stall holds the result; the state
// registers update in the same cycle an update is taken; the next may follow.
// Reset: asynchronous, active low; mode idle, motors stopped, fault clear,
// configuration registers at their default values, no result pending.
module sumo_robot_behaviour_fsm
    import srbf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write port
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    // update input
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [31:0]               now_ms,
    input  logic                      button_down,
    input  logic                      on_edge,
    input  logic                      edge_on_right,
    input  logic [2:0]                opponent_dir,
    input  logic                      fault_request,
    // result output
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [MOTOR_W-1:0] left_speed,
    output logic signed [MOTOR_W-1:0] right_speed,
    output logic [2:0]                mode,
    output logic                      calibrate_strobe,
    output logic                      standby_off
);

    // Configuration registers
    logic [SPEED_W-1:0] attack_speed_reg, turn_speed_reg, search_speed_reg;
    logic [TIME_W-1:0]  start_delay_reg, sweep_seg_reg, attack_wdog_reg;
    logic [TIME_W-1:0]  evade_rev_reg, evade_turn_reg;

    // Behaviour state
    mode_t                      mode_reg, mode_next;
    logic [31:0]                mode_entered_reg, mode_entered_next;
    logic [31:0]                attack_start_reg, attack_start_next;
    logic                       fault_reg, fault_next;
    logic                       evade_turning_reg, evade_turning_next;
    logic [31:0]                evade_phase_reg, evade_phase_next;
    logic                       evade_right_reg, evade_right_next;
    logic                       evade_chosen_reg, evade_chosen_next;
    logic [31:0]                sweep_start_reg, sweep_start_next;
    logic                       sweep_left_reg, sweep_left_next;
    logic                       button_prev_reg, button_prev_next;
    logic signed [MOTOR_W-1:0]  left_cmd_reg, left_cmd_next;
    logic signed [MOTOR_W-1:0]  right_cmd_reg, right_cmd_next;
    logic                       cal_reg, cal_next;
    logic                       stby_reg, stby_next;
    logic                       out_valid_reg;

    logic                       accept;
    mode_t                      mode_eff;
    logic [2:0]                 opp;
    logic                       cal_done, count_done, sweep_done, wdog_done;
    logic                       rev_done, turn_done;
    logic [31:0]                cal_elapsed, count_elapsed, sweep_elapsed;
    logic [31:0]                wdog_elapsed, evade_elapsed;
    logic [SPEED_W-1:0]         slow;

    // Handshake: take a transaction whenever the result register is free
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // Fault latch, and the mode the update runs in
    assign fault_next = fault_reg | fault_request;
    assign mode_eff   = (fault_next && mode_reg != MODE_STOP) ? MODE_STOP : mode_reg;
    assign opp        = (opponent_dir == OPP_UNUSED) ? OPP_NONE : opponent_dir;

    // Timer compares, all differences wrap modulo 2^32
    assign cal_elapsed   = now_ms - mode_entered_reg;
    assign count_elapsed = now_ms - mode_entered_reg;
    assign sweep_elapsed = now_ms - sweep_start_reg;
    assign wdog_elapsed  = now_ms - attack_start_reg;
    assign evade_elapsed = now_ms - evade_phase_reg;
    assign cal_done   = cal_elapsed >= CAL_TIME_MS;
    assign count_done = count_elapsed >= {16'd0, start_delay_reg};
    assign sweep_done = sweep_elapsed >= {16'd0, sweep_seg_reg};
    assign wdog_done  = wdog_elapsed >= {16'd0, attack_wdog_reg};
    assign rev_done   = evade_elapsed >= {16'd0, evade_rev_reg};
    assign turn_done  = evade_elapsed >= {16'd0, evade_turn_reg};

    assign slow = veer_slow(attack_speed_reg);

    // Next state
    always_comb
    begin
        mode_next          = mode_eff;
        mode_entered_next  = (mode_eff != mode_reg) ? now_ms : mode_entered_reg;
        attack_start_next  = attack_start_reg;
        evade_turning_next = evade_turning_reg;
        evade_phase_next   = evade_phase_reg;
        evade_right_next   = evade_right_reg;
        evade_chosen_next  = evade_chosen_reg;
        sweep_start_next   = sweep_start_reg;
        sweep_left_next    = sweep_left_reg;
        button_prev_next   = button_prev_reg;
        unique case (mode_eff)
            MODE_IDLE:
            begin
                button_prev_next = button_down;
                if (button_down && !button_prev_reg)
                begin
                    mode_next         = MODE_CAL;
                    mode_entered_next = now_ms;
                end
            end
            MODE_CAL:
            begin
                if (cal_done)
                begin
                    mode_next         = MODE_COUNT;
                    mode_entered_next = now_ms;
                end
            end
            MODE_COUNT:
            begin
                if (count_done)
                begin
                    mode_next         = MODE_SEARCH;
                    mode_entered_next = now_ms;
                    sweep_start_next  = now_ms;
                end
            end
            MODE_SEARCH:
            begin
                if (on_edge)
                begin
                    mode_next          = MODE_EVADE;
                    mode_entered_next  = now_ms;
                    evade_turning_next = 1'b0;
                    evade_phase_next   = now_ms;
                    evade_chosen_next  = 1'b0;
                end
                else if (opp != OPP_NONE)
                begin
                    mode_next         = MODE_ATTACK;
                    mode_entered_next = now_ms;
                    attack_start_next = now_ms;
                end
                else if (sweep_done)
                begin
                    sweep_left_next  = ~sweep_left_reg;
                    sweep_start_next = now_ms;
                end
            end
            MODE_ATTACK:
            begin
                if (on_edge)
                begin
                    mode_next          = MODE_EVADE;
                    mode_entered_next  = now_ms;
                    evade_turning_next = 1'b0;
                    evade_phase_next   = now_ms;
                    evade_chosen_next  = 1'b0;
                end
                else if (wdog_done || opp == OPP_NONE)
                begin
                    mode_next         = MODE_SEARCH;
                    mode_entered_next = now_ms;
                    sweep_start_next  = now_ms;
                end
            end
            MODE_EVADE:
            begin
                if (!evade_turning_reg)
                begin
                    if (!evade_chosen_reg)
                    begin
                        evade_right_next  = ~edge_on_right;
                        evade_chosen_next = 1'b1;
                    end
                    if (rev_done)
                    begin
                        evade_turning_next = 1'b1;
                        evade_phase_next   = now_ms;
                    end
                end
                else if (turn_done)
                begin
                    if (!on_edge)
                    begin
                        mode_next         = MODE_SEARCH;
                        mode_entered_next = now_ms;
                        sweep_start_next  = now_ms;
                    end
                    else
                    begin
                        evade_turning_next = 1'b0;
                        evade_phase_next   = now_ms;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_STOP;
            end
        endcase
    end

    // Motor command and strobes
    always_comb
    begin
        left_cmd_next  = left_cmd_reg;
        right_cmd_next = right_cmd_reg;
        cal_next       = 1'b0;
        stby_next      = 1'b0;
        unique case (mode_eff) inside
            MODE_IDLE, MODE_COUNT:
            begin
                left_cmd_next  = '0;
                right_cmd_next = '0;
            end
            MODE_CAL:
            begin
                cal_next = 1'b1;
                if (cal_done)
                begin
                    left_cmd_next  = '0;
                    right_cmd_next = '0;
                end
                else
                begin
                    left_cmd_next  = fwd(search_speed_reg);
                    right_cmd_next = rev(search_speed_reg);
                end
            end
            MODE_SEARCH:
            begin
                if (!on_edge && opp == OPP_NONE)
                begin
                    if (sweep_left_next)
                    begin
                        left_cmd_next  = rev(search_speed_reg);
                        right_cmd_next = fwd(search_speed_reg);
                    end
                    else
                    begin
                        left_cmd_next  = fwd(search_speed_reg);
                        right_cmd_next = rev(search_speed_reg);
                    end
                end
            end
            MODE_ATTACK:
            begin
                if (!on_edge && !wdog_done)
                begin
                    // steer toward the bearing
                    case (opp) inside
                        OPP_FRONT:
                        begin
                            left_cmd_next  = fwd(attack_speed_reg);
                            right_cmd_next = fwd(attack_speed_reg);
                        end
                        OPP_FRONT_LEFT:
                        begin
                            left_cmd_next  = fwd(slow);
                            right_cmd_next = fwd(attack_speed_reg);
                        end
                        OPP_FRONT_RIGHT:
                        begin
                            left_cmd_next  = fwd(attack_speed_reg);
                            right_cmd_next = fwd(slow);
                        end
                        OPP_LEFT:
                        begin
                            left_cmd_next  = rev(turn_speed_reg);
                            right_cmd_next = fwd(turn_speed_reg);
                        end
                        OPP_RIGHT, OPP_REAR:
                        begin
                            left_cmd_next  = fwd(turn_speed_reg);
                            right_cmd_next = rev(turn_speed_reg);
                        end
                        default:
                        begin
                            left_cmd_next  = left_cmd_reg;
                            right_cmd_next = right_cmd_reg;
                        end
                    endcase
                end
            end
            MODE_EVADE:
            begin
                if (!evade_turning_reg)
                begin
                    left_cmd_next  = rev(turn_speed_reg);
                    right_cmd_next = rev(turn_speed_reg);
                end
                else if (evade_right_reg)
                begin
                    left_cmd_next  = fwd(turn_speed_reg);
                    right_cmd_next = rev(turn_speed_reg);
                end
                else
                begin
                    left_cmd_next  = rev(turn_speed_reg);
                    right_cmd_next = fwd(turn_speed_reg);
                end
            end
            default:
            begin
                left_cmd_next  = '0;
                right_cmd_next = '0;
                stby_next      = 1'b1;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_speed_reg <= RST_ATTACK_SPEED;
            turn_speed_reg   <= RST_TURN_SPEED;
            search_speed_reg <= RST_SEARCH_SPEED;
            start_delay_reg  <= RST_START_DELAY;
            sweep_seg_reg    <= RST_SWEEP_SEG;
            attack_wdog_reg  <= RST_ATTACK_WDOG;
            evade_rev_reg    <= RST_EVADE_REV;
            evade_turn_reg   <= RST_EVADE_TURN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ATTACK_SPEED:  attack_speed_reg <= cfg_data[SPEED_W-1:0];
                CFG_TURN_SPEED:    turn_speed_reg   <= cfg_data[SPEED_W-1:0];
                CFG_SEARCH_SPEED:  search_speed_reg <= cfg_data[SPEED_W-1:0];
                CFG_START_DELAY:   start_delay_reg  <= cfg_data;
                CFG_SWEEP_SEGMENT: sweep_seg_reg    <= cfg_data;
                CFG_ATTACK_WDOG:   attack_wdog_reg  <= cfg_data;
                CFG_EVADE_REVERSE: evade_rev_reg    <= cfg_data;
                CFG_EVADE_TURN:    evade_turn_reg   <= cfg_data;
                default:           attack_speed_reg <= attack_speed_reg;
            endcase
        end
    end

    // State and result registers, updated per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            mode_entered_reg  <= '0;
            attack_start_reg  <= '0;
            fault_reg         <= 1'b0;
            evade_turning_reg <= 1'b0;
            evade_phase_reg   <= '0;
            evade_right_reg   <= 1'b1;
            evade_chosen_reg  <= 1'b0;
            sweep_start_reg   <= '0;
            sweep_left_reg    <= 1'b1;
            button_prev_reg   <= 1'b0;
            left_cmd_reg      <= '0;
            right_cmd_reg     <= '0;
            cal_reg           <= 1'b0;
            stby_reg          <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg          <= mode_next;
            mode_entered_reg  <= mode_entered_next;
            attack_start_reg  <= attack_start_next;
            fault_reg         <= fault_next;
            evade_turning_reg <= evade_turning_next;
            evade_phase_reg   <= evade_phase_next;
            evade_right_reg   <= evade_right_next;
            evade_chosen_reg  <= evade_chosen_next;
            sweep_start_reg   <= sweep_start_next;
            sweep_left_reg    <= sweep_left_next;
            button_prev_reg   <= button_prev_next;
            left_cmd_reg      <= left_cmd_next;
            right_cmd_reg     <= right_cmd_next;
            cal_reg           <= cal_next;
            stby_reg          <= stby_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign left_speed       = left_cmd_reg;
    assign right_speed      = right_cmd_reg;
    assign mode             = mode_reg;
    assign calibrate_strobe = cal_reg;
    assign standby_off      = stby_reg;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sumo behaviour FSM. A behavioural predictor
// tracks mode, timers and the held motor command for every update taken,
// and each result transaction is compared field by field with the oldest
// prediction. Stimulus walks the start sequence, then random updates with
// boundary-seeking timestamps under several configurations, then faults.
// ----------------------------------------------------------------------------
module tb_top
    import srbf_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int VEER_NUM       = 3;
    localparam int VEER_DEN       = 5;
    localparam int PHASE_UPDATES  = 200;

    typedef struct {
        logic [31:0] now;
        logic        button;
        logic        ring_edge;
        logic        edge_right;
        logic [2:0]  bearing;
        logic        fault;
    } update_t;

    typedef struct {
        logic signed [MOTOR_W-1:0] lspd;
        logic signed [MOTOR_W-1:0] rspd;
        mode_t                     md;
        logic                      strobe;
        logic                      standby;
    } motor_cmd_t;

    typedef logic [CFG_W-1:0] cfg_set_t [8];

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [2:0]                cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [31:0]               now_ms = '0;
    logic                      button_down = 1'b0;
    logic                      on_edge = 1'b0;
    logic                      edge_on_right = 1'b0;
    logic [2:0]                opponent_dir = '0;
    logic                      fault_request = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [MOTOR_W-1:0] left_speed;
    logic signed [MOTOR_W-1:0] right_speed;
    logic [2:0]                mode;
    logic                      calibrate_strobe;
    logic                      standby_off;

    // Predicted results awaiting their transaction on the output side
    motor_cmd_t pending_cmds[$];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         src_idle_pct = 0;
    int         dst_stall_pct = 0;
    logic [31:0] t_now = '0;

    // Predictor copy of the configuration
    logic [SPEED_W-1:0] attack_spd;
    logic [SPEED_W-1:0] turn_spd;
    logic [SPEED_W-1:0] search_spd;
    logic [TIME_W-1:0]  start_delay;
    logic [TIME_W-1:0]  sweep_ms;
    logic [TIME_W-1:0]  wdog_ms;
    logic [TIME_W-1:0]  reverse_ms;
    logic [TIME_W-1:0]  turn_ms;

    // Predictor copy of the behaviour state
    mode_t                     cur_mode = MODE_IDLE;
    logic [31:0]               mode_since = '0;
    logic [31:0]               attack_since = '0;
    logic                      fault_held = 1'b0;
    logic                      ev_turning = 1'b0;
    logic [31:0]               ev_since = '0;
    logic                      ev_turn_right = 1'b1;
    logic                      ev_dir_set = 1'b0;
    logic [31:0]               sweep_since = '0;
    logic                      sweep_left = 1'b1;
    logic                      btn_prev = 1'b0;
    logic signed [MOTOR_W-1:0] left_hold = '0;
    logic signed [MOTOR_W-1:0] right_hold = '0;

    sumo_robot_behaviour_fsm DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .now_ms           (now_ms),
        .button_down      (button_down),
        .on_edge          (on_edge),
        .edge_on_right    (edge_on_right),
        .opponent_dir     (opponent_dir),
        .fault_request    (fault_request),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .left_speed       (left_speed),
        .right_speed      (right_speed),
        .mode             (mode),
        .calibrate_strobe (calibrate_strobe),
        .standby_off      (standby_off)
    );

    always #1 clk = ~clk;

    // Wrapping time since a mark
    function automatic logic [31:0] elapsed(input logic [31:0] t, input logic [31:0] mark);
        return t - mark;
    endfunction

    task automatic enter_mode(input mode_t m, input logic [31:0] t);
        cur_mode   = m;
        mode_since = t;
        if (m == MODE_ATTACK)
            attack_since = t;
        if (m == MODE_EVADE)
        begin
            ev_turning = 1'b0;
            ev_since   = t;
            ev_dir_set = 1'b0;
        end
        if (m == MODE_SEARCH)
            sweep_since = t;
    endtask

    task automatic set_wheels(input logic signed [MOTOR_W-1:0] l,
                              input logic signed [MOTOR_W-1:0] r);
        left_hold  = l;
        right_hold = r;
    endtask

    // Behaviour step: updates the predicted state and returns the command
    task automatic advance_behaviour(input update_t u, output motor_cmd_t cmd);
        logic [2:0]                dir;
        logic                      strobe;
        logic                      standby;
        logic                      rise;
        logic signed [MOTOR_W-1:0] ss;
        logic signed [MOTOR_W-1:0] ts;
        logic signed [MOTOR_W-1:0] as;
        logic signed [MOTOR_W-1:0] slow;
        int                        veer;

        dir     = (u.bearing == OPP_UNUSED) ? OPP_NONE : u.bearing;
        strobe  = 1'b0;
        standby = 1'b0;
        ss      = $signed({1'b0, search_spd});
        ts      = $signed({1'b0, turn_spd});
        as      = $signed({1'b0, attack_spd});
        veer    = int'(attack_spd);
        veer    = veer * VEER_NUM / VEER_DEN;
        slow    = veer[MOTOR_W-1:0];

        if (u.fault)
            fault_held = 1'b1;
        if (fault_held && cur_mode != MODE_STOP)
            enter_mode(MODE_STOP, u.now);

        case (cur_mode)
            MODE_IDLE:
            begin
                rise = u.button && !btn_prev;
                set_wheels('0, '0);
                btn_prev = u.button;
                if (rise)
                    enter_mode(MODE_CAL, u.now);
            end
            MODE_CAL:
            begin
                set_wheels(ss, -ss);
                strobe = 1'b1;
                if (elapsed(u.now, mode_since) >= CAL_TIME_MS)
                begin
                    set_wheels('0, '0);
                    enter_mode(MODE_COUNT, u.now);
                end
            end
            MODE_COUNT:
            begin
                set_wheels('0, '0);
                if (elapsed(u.now, mode_since) >= 32'(start_delay))
                    enter_mode(MODE_SEARCH, u.now);
            end
            MODE_SEARCH:
            begin
                if (u.ring_edge)
                    enter_mode(MODE_EVADE, u.now);
                else if (dir != OPP_NONE)
                    enter_mode(MODE_ATTACK, u.now);
                else
                begin
                    if (elapsed(u.now, sweep_since) >= 32'(sweep_ms))
                    begin
                        sweep_left  = !sweep_left;
                        sweep_since = u.now;
                    end
                    if (sweep_left)
                        set_wheels(-ss, ss);
                    else
                        set_wheels(ss, -ss);
                end
            end
            MODE_ATTACK:
            begin
                if (u.ring_edge)
                    enter_mode(MODE_EVADE, u.now);
                else if (elapsed(u.now, attack_since) >= 32'(wdog_ms))
                    enter_mode(MODE_SEARCH, u.now);
                else if (dir == OPP_NONE)
                    enter_mode(MODE_SEARCH, u.now);
                else
                begin
                    case (dir)
                        OPP_FRONT:       set_wheels(as, as);
                        OPP_FRONT_LEFT:  set_wheels(slow, as);
                        OPP_FRONT_RIGHT: set_wheels(as, slow);
                        OPP_LEFT:        set_wheels(-ts, ts);
                        default:         set_wheels(ts, -ts);  // right and rear
                    endcase
                end
            end
            MODE_EVADE:
            begin
                if (!ev_turning)
                begin
                    // turn direction fixed once per evade entry
                    if (!ev_dir_set)
                    begin
                        ev_turn_right = !u.edge_right;
                        ev_dir_set    = 1'b1;
                    end
                    set_wheels(-ts, -ts);
                    if (elapsed(u.now, ev_since) >= 32'(reverse_ms))
                    begin
                        ev_turning = 1'b1;
                        ev_since   = u.now;
                    end
                end
                else
                begin
                    if (ev_turn_right)
                        set_wheels(ts, -ts);
                    else
                        set_wheels(-ts, ts);
                    if (elapsed(u.now, ev_since) >= 32'(turn_ms))
                    begin
                        if (!u.ring_edge)
                            enter_mode(MODE_SEARCH, u.now);
                        else
                        begin
                            ev_turning = 1'b0;
                            ev_since   = u.now;
                        end
                    end
                end
            end
            default:
            begin
                cur_mode = MODE_STOP;
                set_wheels('0, '0);
                standby = 1'b1;
            end
        endcase

        cmd.lspd    = left_hold;
        cmd.rspd    = right_hold;
        cmd.md      = cur_mode;
        cmd.strobe  = strobe;
        cmd.standby = standby;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Write every register in turn; the block is idle when this is called
    task automatic program_config(input cfg_set_t v);
        cfg_idx_t idx;
        for (int i = 0; i < 8; i++)
        begin
            idx       = cfg_idx_t'(i);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= v[i];
            @(posedge clk);
            case (idx)
                CFG_ATTACK_SPEED:  attack_spd  = v[i][SPEED_W-1:0];
                CFG_TURN_SPEED:    turn_spd    = v[i][SPEED_W-1:0];
                CFG_SEARCH_SPEED:  search_spd  = v[i][SPEED_W-1:0];
                CFG_START_DELAY:   start_delay = v[i][TIME_W-1:0];
                CFG_SWEEP_SEGMENT: sweep_ms    = v[i][TIME_W-1:0];
                CFG_ATTACK_WDOG:   wdog_ms     = v[i][TIME_W-1:0];
                CFG_EVADE_REVERSE: reverse_ms  = v[i][TIME_W-1:0];
                default:           turn_ms     = v[i][TIME_W-1:0];
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // Send one update transaction and log its predicted result on acceptance
    task automatic send_update(input logic [31:0] t, input logic btn, input logic ring,
                               input logic er, input logic [2:0] bearing,
                               input logic fault);
        update_t    u;
        motor_cmd_t cmd;

        u = '{t, btn, ring, er, bearing, fault};
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        in_valid      <= 1'b1;
        now_ms        <= t;
        button_down   <= btn;
        on_edge       <= ring;
        edge_on_right <= er;
        opponent_dir  <= bearing;
        fault_request <= fault;
        do
            @(posedge clk);
        while (in_stall);
        advance_behaviour(u, cmd);
        pending_cmds.push_back(cmd);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Next timestamp: small steps, long jumps, full wraps, and often a
    // point just before or on the deadline of the current mode's timer
    task automatic advance_clock();
        logic [31:0] mark;
        logic [31:0] span;

        case ($urandom_range(0, 9)) inside
            [0:2]: t_now = t_now + $urandom_range(0, 20);
            [3:4]:
            begin
                case (cur_mode)
                    MODE_CAL:    begin mark = mode_since;   span = CAL_TIME_MS;      end
                    MODE_COUNT:  begin mark = mode_since;   span = 32'(start_delay); end
                    MODE_SEARCH: begin mark = sweep_since;  span = 32'(sweep_ms);    end
                    MODE_ATTACK: begin mark = attack_since; span = 32'(wdog_ms);     end
                    MODE_EVADE:
                    begin
                        mark = ev_since;
                        span = ev_turning ? 32'(turn_ms) : 32'(reverse_ms);
                    end
                    default:     begin mark = t_now;        span = '0;               end
                endcase
                t_now = mark + span - $urandom_range(0, 1);
            end
            [5:7]:   t_now = t_now + $urandom_range(0, 700);
            8:       t_now = t_now + $urandom_range(0, 70000);
            default: t_now = $urandom;
        endcase
    endtask

    task automatic send_random_update(input logic fault);
        logic [2:0] bearing;

        advance_clock();
        if ($urandom_range(0, 1))
            bearing = $urandom_range(0, 1) ? OPP_NONE : OPP_UNUSED;
        else
            bearing = 3'($urandom_range(int'(OPP_FRONT), int'(OPP_REAR)));
        send_update(t_now, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                    1'($urandom_range(0, 1)), bearing, fault);
    endtask

    // Start sequence and every mode but stop, with the reset configuration
    task automatic test_start_sequence();
        t_now = 32'hFFFF_F100;
        send_update(t_now, 1'b0, 1'b0, 1'b0, OPP_NONE, 1'b0);
        send_update(t_now + 5, 1'b0, 1'b1, 1'b1, OPP_UNUSED, 1'b0);
        // button rise after a released sample starts calibration
        t_now += 10;
        send_update(t_now, 1'b1, 1'b0, 1'b0, OPP_NONE, 1'b0);
        send_update(t_now + 1, 1'b1, 1'b1, 1'b0, OPP_FRONT, 1'b0);
        send_update(t_now + CAL_TIME_MS - 1, 1'b0, 1'b0, 1'b0, OPP_NONE, 1'b0);
        // calibration end lands after the timestamp wraps through zero
        t_now += CAL_TIME_MS;
        send_update(t_now, 1'b0, 1'b0, 1'b0, OPP_NONE, 1'b0);
        send_update(t_now + 32'(RST_START_DELAY) - 1, 1'b0, 1'b1, 1'b0, OPP_LEFT, 1'b0);
        t_now += 32'(RST_START_DELAY);
        send_update(t_now, 1'b0, 1'b0, 1'b0, OPP_NONE, 1'b0);
        // sweep, with the unused bearing seen as no opponent
        send_update(t_now + 10, 1'b0, 1'b0, 1'b0, OPP_UNUSED, 1'b0);
        t_now += 32'(RST_SWEEP_SEG);
        send_update(t_now, 1'b0, 1'b0, 1'b0, OPP_NONE, 1'b0);
        t_now += 5;
        send_update(t_now, 1'b0, 1'b0, 1'b0, OPP_FRONT, 1'b0);
        // steering for every bearing
        for (int b = int'(OPP_FRONT); b <= int'(OPP_REAR); b++)
        begin
            t_now += 1;
            send_update(t_now, 1'b0, 1'b0, 1'b0, 3'(b), 1'b0);
        end
        t_now += 1;
        send_update(t_now, 1'b0, 1'b0, 1'b0, OPP_UNUSED, 1'b0);
        t_now += 1;
        send_update(t_now, 1'b0, 1'b0, 1'b0, OPP_FRONT, 1'b0);
        // attack watchdog wins over a present opponent
        t_now += 32'(RST_ATTACK_WDOG);
        send_update(t_now, 1'b0, 1'b0, 1'b0, OPP_FRONT, 1'b0);
        // evade: reverse, turn, repeat while on the edge, then leave
        t_now += 1;
        send_update(t_now, 1'b0, 1'b1, 1'b1, OPP_FRONT, 1'b0);
        t_now += 1;
        send_update(t_now, 1'b0, 1'b1, 1'b1, OPP_NONE, 1'b0);
        t_now += 32'(RST_EVADE_REV);
        send_update(t_now, 1'b0, 1'b1, 1'b0, OPP_NONE, 1'b0);
        t_now += 32'(RST_EVADE_TURN);
        send_update(t_now, 1'b0, 1'b1, 1'b0, OPP_REAR, 1'b0);
        t_now += 32'(RST_EVADE_REV);
        send_update(t_now, 1'b0, 1'b0, 1'b0, OPP_NONE, 1'b0);
        t_now += 32'(RST_EVADE_TURN);
        send_update(t_now, 1'b0, 1'b0, 1'b1, OPP_NONE, 1'b0);
    endtask

    // Random updates under a run of configurations and idling patterns
    task automatic test_random_traffic();
        cfg_set_t cfg;

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_results_drained();
            for (int i = 0; i < 8; i++)
            begin
                if (ph == 0)
                    cfg[i] = '0;
                else if (ph == 3)
                    cfg[i] = '1;
                else if (i <= int'(CFG_SEARCH_SPEED))
                    cfg[i] = 16'($urandom_range(0, 16'hFFFF));
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       cfg[i] = 16'($urandom_range(0, 20));
                        1:       cfg[i] = 16'($urandom_range(0, 16'hFFFF));
                        default: cfg[i] = 16'($urandom_range(0, 800));
                    endcase
                end
            end
            program_config(cfg);
            case (ph / 2)
                0:       begin src_idle_pct = 10; dst_stall_pct = 64; end
                1:       begin src_idle_pct = 64; dst_stall_pct = 10; end
                default: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
            endcase
            repeat (PHASE_UPDATES) send_random_update(1'b0);
        end
    endtask

    // Fault latch forces stop, a second fault in stop, and stop never exits
    task automatic test_fault_latch();
        repeat (5) send_random_update(1'b0);
        send_random_update(1'b1);
        send_random_update(1'b1);
        repeat (30) send_random_update(1'($urandom_range(0, 1)));
    endtask

    // Receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < dst_stall_pct);

    // Result checker
    always @(posedge clk)
    begin
        motor_cmd_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_cmds.size() == 0)
                report_mismatch("unexpected result, mode", int'(mode), 0);
            else
            begin
                want = pending_cmds.pop_front();
                if (left_speed !== want.lspd)
                    report_mismatch("left_speed", int'(left_speed), int'(want.lspd));
                if (right_speed !== want.rspd)
                    report_mismatch("right_speed", int'(right_speed), int'(want.rspd));
                if (mode !== want.md)
                    report_mismatch("mode", int'(mode), int'(want.md));
                if (calibrate_strobe !== want.strobe)
                    report_mismatch("calibrate_strobe", int'(calibrate_strobe),
                                    int'(want.strobe));
                if (standby_off !== want.standby)
                    report_mismatch("standby_off", int'(standby_off), int'(want.standby));
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        attack_spd  = RST_ATTACK_SPEED;
        turn_spd    = RST_TURN_SPEED;
        search_spd  = RST_SEARCH_SPEED;
        start_delay = RST_START_DELAY;
        sweep_ms    = RST_SWEEP_SEG;
        wdog_ms     = RST_ATTACK_WDOG;
        reverse_ms  = RST_EVADE_REV;
        turn_ms     = RST_EVADE_TURN;
        src_idle_pct  = 10;
        dst_stall_pct = 64;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_start_sequence();
        test_random_traffic();
        test_fault_latch();

        wait_results_drained();
        repeat (4) @(posedge clk);
        if (pending_cmds.size() != 0)
            report_mismatch("results left over", pending_cmds.size(), 0);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sumo_robot_behaviour_fsm.f -----
hdl/srbf_pkg.sv
hdl/sumo_robot_behaviour_fsm.sv
test/tb_top.sv
